### hw/rtl/xtr_pkg.sv
package xtr_pkg;

  // Field widths
  localparam int COEF_W = 18;
  localparam int ROW_W  = 54;
  localparam int PIX_W  = 16;
  localparam int PROD_W = 35;
  localparam int CH_W   = 37;
  localparam int C_W    = 36;
  localparam int DIV_W  = 52;
  localparam int Q_W    = 16;
  localparam int NCH    = 3;

  // Register indexes
  typedef enum logic [1:0] {
    REG_RED   = 2'd0,
    REG_GREEN = 2'd1,
    REG_BLUE  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] in_x;
    logic [PIX_W-1:0] in_y;
    logic [PIX_W-1:0] in_z;
    logic [PIX_W-1:0] norm_max;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_red;
    logic [PIX_W-1:0] out_green;
    logic [PIX_W-1:0] out_blue;
    logic             desaturated;
    logic             clipped;
  } out_item_t;

  // State handed from one divider cell to the next
  typedef struct packed {
    logic                      vld;
    logic [NCH-1:0][DIV_W-1:0] rem;
    logic [C_W-1:0]            den;
    logic [NCH-1:0][Q_W-1:0]   quo;
    logic [NCH-1:0]            ovf;
    logic                      desat;
    logic                      zero;
  } div_t;

endpackage

### hw/rtl/xtr_front.sv
module xtr_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_vld,
  input  xtr_pkg::in_item_t                in_item,
  input  logic [2:0][xtr_pkg::ROW_W-1:0]   rows,
  output xtr_pkg::div_t                    div_out
);
  import xtr_pkg::*;

  // Stage 1: nine products
  logic [3:0]                       vld_r;
  logic signed [PROD_W-1:0]         prod_r [NCH][NCH];
  logic [PIX_W-1:0]                 d1_r, d2_r, d3_r, d4_r;
  logic signed [CH_W-1:0]           ch_r [NCH];
  logic [C_W-1:0]                   c3_r [NCH];
  logic [C_W-1:0]                   c4_r [NCH];
  logic [C_W-1:0]                   mx4_r;
  logic                             ds3_r, ds4_r;
  logic signed [PIX_W:0]            pix [NCH];
  div_t                             div_r, div_nxt;

  assign pix[0] = $signed({1'b0, in_item.in_x});
  assign pix[1] = $signed({1'b0, in_item.in_y});
  assign pix[2] = $signed({1'b0, in_item.in_z});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < NCH; r++) begin
        for (int k = 0; k < NCH; k++) begin
          prod_r[r][k] <= $signed(rows[r][COEF_W*k +: COEF_W]) * pix[k];
        end
      end
      d1_r <= in_item.norm_max;
    end
  end

  // Stage 2: row sums
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < NCH; r++) begin
        ch_r[r] <= CH_W'(prod_r[r][0]) + CH_W'(prod_r[r][1]) + CH_W'(prod_r[r][2]);
      end
      d2_r <= d1_r;
    end
  end

  // Stage 3: desaturate by the smallest channel when it is negative
  logic signed [CH_W-1:0] mn;
  logic                   neg;
  always_comb begin
    mn = ch_r[0];
    if (ch_r[1] < mn) mn = ch_r[1];
    if (ch_r[2] < mn) mn = ch_r[2];
    neg = mn[CH_W-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < NCH; r++) begin
        c3_r[r] <= neg ? C_W'(ch_r[r] - mn) : C_W'(ch_r[r]);
      end
      ds3_r <= neg;
      d3_r  <= d2_r;
    end
  end

  // Stage 4: largest channel
  logic [C_W-1:0] mx;
  always_comb begin
    mx = c3_r[0];
    if (c3_r[1] > mx) mx = c3_r[1];
    if (c3_r[2] > mx) mx = c3_r[2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c4_r  <= c3_r;
      mx4_r <= mx;
      ds4_r <= ds3_r;
      d4_r  <= d3_r;
    end
  end

  // Stage 5: numerator, divisor and saturation pre-check
  logic [DIV_W-1:0] den_top;
  always_comb begin
    div_nxt       = '0;
    div_nxt.vld   = vld_r[3];
    div_nxt.den   = (d4_r != '0) ? C_W'(d4_r) : mx4_r;
    div_nxt.desat = ds4_r;
    div_nxt.zero  = (mx4_r == '0);
    den_top       = {div_nxt.den, {(DIV_W-C_W){1'b0}}};
    for (int r = 0; r < NCH; r++) begin
      div_nxt.rem[r] = (d4_r != '0) ? (DIV_W'(c4_r[r]) << 1) : (DIV_W'(c4_r[r]) << 15);
      div_nxt.ovf[r] = (div_nxt.rem[r] >= den_top);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r.vld <= 1'b0;
    end else if (en) begin
      div_r.vld <= div_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r.rem   <= div_nxt.rem;
      div_r.den   <= div_nxt.den;
      div_r.quo   <= div_nxt.quo;
      div_r.ovf   <= div_nxt.ovf;
      div_r.desat <= div_nxt.desat;
      div_r.zero  <= div_nxt.zero;
    end
  end

  assign div_out = div_r;

endmodule

### hw/rtl/xtr_div_cell.sv
module xtr_div_cell #(
  parameter int STEP = 15
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  xtr_pkg::div_t  div_in,
  output xtr_pkg::div_t  div_out
);
  import xtr_pkg::*;

  div_t             div_r, div_nxt;
  logic [DIV_W-1:0] sub;

  // One restoring step: quotient bit STEP for every lane
  always_comb begin
    div_nxt = div_in;
    sub     = DIV_W'(div_in.den) << STEP;
    for (int r = 0; r < NCH; r++) begin
      if (div_in.rem[r] >= sub) begin
        div_nxt.rem[r]       = div_in.rem[r] - sub;
        div_nxt.quo[r][STEP] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r.vld <= 1'b0;
    end else if (en) begin
      div_r.vld <= div_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r.rem   <= div_nxt.rem;
      div_r.den   <= div_nxt.den;
      div_r.quo   <= div_nxt.quo;
      div_r.ovf   <= div_nxt.ovf;
      div_r.desat <= div_nxt.desat;
      div_r.zero  <= div_nxt.zero;
    end
  end

  assign div_out = div_r;

endmodule

### hw/rtl/xyz_to_rgb_gamut_normalize.sv
// The pipe has 5 front stages, 16 divider cells and 1 output register.
// Throughput: one sample per cycle; the row of divider cells, one quotient
// bit per cell, keeps every stage busy. A stalled output freezes the whole pipe.
// Reset (rst_n low, synchronous) empties the pipe and loads the identity matrix.
module xyz_to_rgb_gamut_normalize (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  xtr_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output xtr_pkg::out_item_t          out_data,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_idx,
  input  logic [xtr_pkg::ROW_W-1:0]   cfg_data
);
  import xtr_pkg::*;

  logic [2:0][ROW_W-1:0] rows_r;
  logic                  en;
  div_t                  chain [Q_W+1];
  logic                  out_valid_r;
  out_item_t             out_r, out_nxt;

  // Pipe advances unless a finished result is held
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // Matrix rows
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r[REG_RED]   <= ROW_W'(64'd16384);
      rows_r[REG_GREEN] <= ROW_W'(64'd1) << 32;
      rows_r[REG_BLUE]  <= ROW_W'(64'd1) << 50;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_RED:   rows_r[REG_RED]   <= cfg_data;
        REG_GREEN: rows_r[REG_GREEN] <= cfg_data;
        REG_BLUE:  rows_r[REG_BLUE]  <= cfg_data;
        default:   ;
      endcase
    end
  end

  xtr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_valid && !in_stall),
    .in_item (in_data),
    .rows    (rows_r),
    .div_out (chain[0])
  );

  // Divider cells, most significant quotient bit first
  for (genvar g = 0; g < Q_W; g++) begin : g_cell
    xtr_div_cell #(.STEP(Q_W-1-g)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .div_in  (chain[g]),
      .div_out (chain[g+1])
    );
  end

  // Saturation and zero colour
  logic [NCH-1:0][Q_W-1:0] q;
  always_comb begin
    for (int r = 0; r < NCH; r++) begin
      q[r] = chain[Q_W].zero ? '0 : (chain[Q_W].ovf[r] ? '1 : chain[Q_W].quo[r]);
    end
    out_nxt.out_red     = q[0];
    out_nxt.out_green   = q[1];
    out_nxt.out_blue    = q[2];
    out_nxt.desaturated = chain[Q_W].desat;
    out_nxt.clipped     = !chain[Q_W].zero && (|chain[Q_W].ovf);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= chain[Q_W].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks
  a_clip_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.clipped |-> (out_data.out_red == '1 ||
      out_data.out_green == '1 || out_data.out_blue == '1))
    else $error("clipped without a saturated channel");

  a_hold_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while result held");

  a_cfg_ignore: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && cfg_idx > REG_BLUE |=> $stable(rows_r))
    else $error("write to unused index changed a row");

endmodule
